// ===== hw/rtl/dslr_pkg.sv =====
// types and constants shared by the double-step line rasterizer
`default_nettype none

package dslr_pkg;

   localparam int COORD_BITS = 12;
   localparam int EXT_BITS   = 5;
   localparam int DEC_BITS   = COORD_BITS + EXT_BITS;
   localparam int STEP_BITS  = COORD_BITS - 2;
   localparam int COLOR_BITS = 16;
   localparam int MAX_RESULTS = 4;
   localparam int CNT_BITS   = 3;

   typedef enum logic {
      OP_START   = 1'b0,
      OP_ADVANCE = 1'b1
   } op_type;

   typedef struct packed {
      op_type                        opcode;
      logic signed [COORD_BITS-1:0]  x_start;
      logic signed [COORD_BITS-1:0]  y_start;
      logic signed [COORD_BITS-1:0]  x_end;
      logic signed [COORD_BITS-1:0]  y_end;
      logic [COLOR_BITS-1:0]         color;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0]  pixel_x;
      logic signed [COORD_BITS-1:0]  pixel_y;
      logic [COLOR_BITS-1:0]         pixel_color;
      logic                          pixel_valid;
      logic                          last_of_run;
      logic                          line_done;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/double_step_line_rasterizer_top.sv =====
// symmetric double-step line rasterizer: setup, double steps, tail and result buffer
//
// A start item latches two endpoints and a color and gives both endpoints as results (one
// result for a zero-length line). Each advance item then takes one double step and gives four
// pixels, two walking forward from the first end and two walking back from the second. The
// advance after the last double step gives the 0 to 3 tail pixels and a bare line_done result,
// and the block goes idle; an advance while idle is taken and gives nothing. All work for an
// item is done in the cycle it is accepted and its 0 to 4 results are written to a four-entry
// result buffer, so the first result appears the cycle after acceptance. The result port moves
// one result per cycle while rsp_ready is high, and the next item is taken once the buffer is
// empty or in the cycle the previous item's last result leaves.
`default_nettype none

module double_step_line_rasterizer_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire dslr_pkg::req_type req_item,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output dslr_pkg::rsp_type     rsp_item
);

   localparam int C = dslr_pkg::COORD_BITS;
   localparam int D = dslr_pkg::DEC_BITS;
   localparam int S = dslr_pkg::STEP_BITS;
   localparam int N = dslr_pkg::MAX_RESULTS;
   localparam int K = dslr_pkg::CNT_BITS;

   // line state
   logic [C-1:0]                   front_x_ff, front_y_ff, back_x_ff, back_y_ff;
   logic [C-1:0]                   front_x_in, front_y_in, back_x_in, back_y_in;
   logic signed [D-1:0]            decision_ff, inc_one_ff, inc_two_ff, bound_ff;
   logic signed [D-1:0]            decision_in, inc_one_in, inc_two_in, bound_in;
   logic [S-1:0]                   steps_ff, steps_in;
   logic [1:0]                     tail_ff, tail_in;
   logic                           ymaj_ff, steep_ff, xneg_ff, yneg_ff;
   logic                           ymaj_in, steep_in, xneg_in, yneg_in;
   logic [dslr_pkg::COLOR_BITS-1:0] color_ff, color_in;
   logic                           active_ff, active_in;

   // result buffer
   dslr_pkg::rsp_type              buf_ff [N];
   dslr_pkg::rsp_type              buf_in [N];
   logic [K-1:0]                   cnt_ff, cnt_in;
   logic [K-1:0]                   new_n;
   dslr_pkg::rsp_type              ent [N];

   logic                           req_fire, rsp_fire;

   function automatic logic [C-1:0] scale(input logic [C-1:0] u, input logic [1:0] k);
      logic [C-1:0] r;
      case (k)
         2'd0:    r = '0;
         2'd1:    r = u;
         2'd2:    r = u << 1;
         default: r = u + (u << 1);
      endcase
      return r;
   endfunction

   function automatic logic [C-1:0] offs(input logic [C-1:0] base, input logic [C-1:0] umaj,
                                         input logic [C-1:0] umin, input logic [1:0] kmaj,
                                         input logic [1:0] kmin, input logic back);
      logic [C-1:0] d;
      d = scale(umaj, kmaj) + scale(umin, kmin);
      return back ? base - d : base + d;
   endfunction

   function automatic dslr_pkg::rsp_type pix(input logic [C-1:0] x, input logic [C-1:0] y,
                                             input logic [dslr_pkg::COLOR_BITS-1:0] col);
      dslr_pkg::rsp_type r;
      r.pixel_x     = x;
      r.pixel_y     = y;
      r.pixel_color = col;
      r.pixel_valid = 1'b1;
      r.last_of_run = 1'b0;
      r.line_done   = 1'b0;
      return r;
   endfunction

   assign rsp_valid = (cnt_ff != '0);
   assign rsp_item  = buf_ff[0];
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign req_ready = (cnt_ff == '0) || ((cnt_ff == K'(1)) && rsp_ready);
   assign req_fire  = req_valid && req_ready;

   // setup for a start item
   logic signed [C:0]   dx_w, dy_w;
   logic [C:0]          adx_w, ady_w;
   logic [C-1:0]        adx, ady, maj, mnr, maj_m1;
   logic signed [D-1:0] majd, mnrd, inc2_s, pb_s, inc1_s, dec_s;
   logic                xmajor;

   always_comb begin
      dx_w   = {req_item.x_end[C-1], req_item.x_end} - {req_item.x_start[C-1], req_item.x_start};
      dy_w   = {req_item.y_end[C-1], req_item.y_end} - {req_item.y_start[C-1], req_item.y_start};
      adx_w  = dx_w[C] ? (~dx_w + 1'b1) : dx_w;
      ady_w  = dy_w[C] ? (~dy_w + 1'b1) : dy_w;
      adx    = adx_w[C-1:0];
      ady    = ady_w[C-1:0];
      xmajor = adx > ady;
      maj    = xmajor ? adx : ady;
      mnr    = xmajor ? ady : adx;
      maj_m1 = maj - 1'b1;
      majd   = signed'({{dslr_pkg::EXT_BITS{1'b0}}, maj});
      mnrd   = signed'({{dslr_pkg::EXT_BITS{1'b0}}, mnr});
      inc2_s = (mnrd <<< 2) - (majd <<< 1);
      pb_s   = inc2_s[D-1] ? (mnrd <<< 1) : ((mnrd - majd) <<< 1);
      inc1_s = pb_s <<< 1;
      dec_s  = inc2_s[D-1] ? (inc1_s - majd) : (inc1_s + majd);
   end

   // unit steps along the major and minor axes
   logic [C-1:0] sx_u, sy_u, umaj_x, umaj_y, umin_x, umin_y;

   always_comb begin
      sx_u   = xneg_ff ? '1 : C'(1);
      sy_u   = yneg_ff ? '1 : C'(1);
      umaj_x = ymaj_ff ? '0 : sx_u;
      umaj_y = ymaj_ff ? sy_u : '0;
      umin_x = ymaj_ff ? sx_u : '0;
      umin_y = ymaj_ff ? '0 : sy_u;
   end

   // pattern selection for a double step and for the tail
   logic       dec_neg, dec_pos, dec_lt, dec_gt;
   logic       first_inc, m1, m2, f1, f2, bk;
   logic [1:0] msum, fsum;

   always_comb begin
      dec_neg = decision_ff < 0;
      dec_pos = decision_ff > 0;
      dec_lt  = decision_ff < bound_ff;
      dec_gt  = decision_ff > bound_ff;
      if (!steep_ff) begin
         first_inc = dec_neg;
         m1        = !dec_neg && !dec_lt;
         m2        = !dec_neg && dec_lt;
         f1        = !dec_neg && !dec_lt;
         f2        = !dec_neg && dec_lt;
         bk        = !dec_neg && !dec_lt;
      end else begin
         first_inc = dec_pos;
         m1        = dec_pos || !dec_lt;
         m2        = dec_pos || dec_lt;
         f1        = dec_pos || !dec_lt;
         f2        = dec_pos || dec_lt;
         bk        = dec_pos || (!dec_lt && dec_gt);
      end
      msum = {1'b0, m1} + {1'b0, m2};
      fsum = {1'b0, f1} + {1'b0, f2};
   end

   // next state and results of the accepted item
   dslr_pkg::rsp_type tp [N];
   dslr_pkg::rsp_type done_r;

   always_comb begin
      front_x_in  = front_x_ff;
      front_y_in  = front_y_ff;
      back_x_in   = back_x_ff;
      back_y_in   = back_y_ff;
      decision_in = decision_ff;
      inc_one_in  = inc_one_ff;
      inc_two_in  = inc_two_ff;
      bound_in    = bound_ff;
      steps_in    = steps_ff;
      tail_in     = tail_ff;
      ymaj_in     = ymaj_ff;
      steep_in    = steep_ff;
      xneg_in     = xneg_ff;
      yneg_in     = yneg_ff;
      color_in    = color_ff;
      active_in   = active_ff;
      new_n       = '0;
      done_r      = '0;
      done_r.line_done = 1'b1;
      for (int i = 0; i < N; i++) begin
         ent[i] = '0;
         tp[i]  = '0;
      end

      if (req_item.opcode == dslr_pkg::OP_START) begin
         front_x_in  = req_item.x_start;
         front_y_in  = req_item.y_start;
         back_x_in   = req_item.x_end;
         back_y_in   = req_item.y_end;
         decision_in = dec_s;
         inc_one_in  = inc1_s;
         inc_two_in  = inc2_s;
         bound_in    = pb_s;
         ymaj_in     = !xmajor;
         steep_in    = !inc2_s[D-1];
         xneg_in     = dx_w[C];
         yneg_in     = dy_w[C];
         color_in    = req_item.color;
         active_in   = 1'b1;
         ent[0]      = pix(req_item.x_start, req_item.y_start, req_item.color);
         ent[1]      = pix(req_item.x_end, req_item.y_end, req_item.color);
         if (maj == '0) begin
            steps_in = '0;
            tail_in  = '0;
            new_n    = K'(1);
         end else begin
            steps_in = maj_m1[C-1:2];
            tail_in  = maj_m1[1:0];
            new_n    = K'(2);
         end
      end else if (active_ff) begin
         if (steps_ff != '0) begin
            ent[0] = pix(offs(front_x_ff, umaj_x, umin_x, 2'd1, {1'b0, m1}, 1'b0),
                         offs(front_y_ff, umaj_y, umin_y, 2'd1, {1'b0, m1}, 1'b0), color_ff);
            ent[1] = pix(offs(front_x_ff, umaj_x, umin_x, 2'd2, msum, 1'b0),
                         offs(front_y_ff, umaj_y, umin_y, 2'd2, msum, 1'b0), color_ff);
            ent[2] = pix(offs(back_x_ff, umaj_x, umin_x, 2'd1, {1'b0, m1}, 1'b1),
                         offs(back_y_ff, umaj_y, umin_y, 2'd1, {1'b0, m1}, 1'b1), color_ff);
            ent[3] = pix(offs(back_x_ff, umaj_x, umin_x, 2'd2, msum, 1'b1),
                         offs(back_y_ff, umaj_y, umin_y, 2'd2, msum, 1'b1), color_ff);
            front_x_in  = ent[1].pixel_x;
            front_y_in  = ent[1].pixel_y;
            back_x_in   = ent[3].pixel_x;
            back_y_in   = ent[3].pixel_y;
            decision_in = decision_ff + (first_inc ? inc_one_ff : inc_two_ff);
            steps_in    = steps_ff - 1'b1;
            new_n       = K'(N);
         end else begin
            tp[0] = pix(offs(front_x_ff, umaj_x, umin_x, 2'd1, {1'b0, f1}, 1'b0),
                        offs(front_y_ff, umaj_y, umin_y, 2'd1, {1'b0, f1}, 1'b0), color_ff);
            tp[1] = pix(offs(front_x_ff, umaj_x, umin_x, 2'd2, fsum, 1'b0),
                        offs(front_y_ff, umaj_y, umin_y, 2'd2, fsum, 1'b0), color_ff);
            tp[2] = pix(offs(back_x_ff, umaj_x, umin_x, 2'd1, {1'b0, bk}, 1'b1),
                        offs(back_y_ff, umaj_y, umin_y, 2'd1, {1'b0, bk}, 1'b1), color_ff);
            for (int i = 0; i < N; i++) begin
               if (2'(i) < tail_ff && i < N - 1) begin
                  ent[i] = tp[i];
               end else if (i == int'(tail_ff)) begin
                  ent[i] = done_r;
               end
            end
            new_n     = K'(tail_ff) + K'(1);
            tail_in   = '0;
            active_in = 1'b0;
         end
      end

      for (int i = 0; i < N; i++) begin
         ent[i].last_of_run = (new_n != '0) && (K'(i) == new_n - K'(1));
      end
   end

   // result buffer: load on accept, shift on each taken result
   always_comb begin
      cnt_in = cnt_ff;
      for (int i = 0; i < N; i++) begin
         buf_in[i] = buf_ff[i];
      end
      if (req_fire) begin
         cnt_in = new_n;
         for (int i = 0; i < N; i++) begin
            buf_in[i] = ent[i];
         end
      end else if (rsp_fire) begin
         cnt_in = cnt_ff - K'(1);
         for (int i = 0; i < N - 1; i++) begin
            buf_in[i] = buf_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         active_ff <= 1'b0;
         steps_ff  <= '0;
         tail_ff   <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (req_fire) begin
            active_ff <= active_in;
            steps_ff  <= steps_in;
            tail_ff   <= tail_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         buf_ff[i] <= buf_in[i];
      end
      if (req_fire) begin
         front_x_ff  <= front_x_in;
         front_y_ff  <= front_y_in;
         back_x_ff   <= back_x_in;
         back_y_ff   <= back_y_in;
         decision_ff <= decision_in;
         inc_one_ff  <= inc_one_in;
         inc_two_ff  <= inc_two_in;
         bound_ff    <= bound_in;
         ymaj_ff     <= ymaj_in;
         steep_ff    <= steep_in;
         xneg_ff     <= xneg_in;
         yneg_ff     <= yneg_in;
         color_ff    <= color_in;
      end
   end

   // checks
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= K'(N))
      else $error("result buffer count out of range");

   a_last_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.last_of_run |-> cnt_ff == K'(1))
      else $error("last_of_run not on final buffered item");

   a_done_bare: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.line_done |-> !rsp_item.pixel_valid && rsp_item.last_of_run)
      else $error("line_done item carries a pixel or is not last");

   a_start_out: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_item.opcode == dslr_pkg::OP_START |=> rsp_valid && active_ff)
      else $error("start item gave no result");

   a_idle_adv: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_item.opcode == dslr_pkg::OP_ADVANCE && !active_ff |=> !rsp_valid)
      else $error("advance while idle gave a result");

endmodule

`default_nettype wire
